// ===== rtl/sqsm_pkg.sv =====
// shared types, codes and sizes for the slotted queue server mux
package sqsm_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int ITEM_WIDTH  = 16;
  localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int LIMIT_W     = 7;
  localparam int SERVICE_W   = 8;
  localparam int CFG_W       = 8;
  localparam int CMP_W       = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  // register indexes on the config port
  localparam logic REG_SERVICE_TIME = 1'b0;
  localparam logic REG_QUEUE_LIMIT  = 1'b1;

  // input commands
  localparam logic CMD_ARRIVAL = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  // result kinds
  localparam logic KIND_DEPART = 1'b0;
  localparam logic KIND_DROP   = 1'b1;

  // server modes
  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_SYNCING = 2'd1;
  localparam logic [1:0] MODE_SERVING = 2'd2;

  typedef logic [ITEM_WIDTH-1:0] item_t;

  // queue operation requested by the controller
  typedef struct packed {
    logic  push;
    logic  pop;
    item_t data;
  } queue_op_t;

  // queue status back to the controller
  typedef struct packed {
    logic [CNT_W-1:0] count;
    item_t            head_data;
  } queue_stat_t;

  // one result beat
  typedef struct packed {
    logic  valid;
    logic  kind;
    item_t item;
  } result_t;

endpackage

// ===== rtl/sqsm_queue.sv =====
// fifo store with head and fill count, head entry kept prefetched
module sqsm_queue (
  input  logic                clk,
  input  logic                rst,
  input  sqsm_pkg::queue_op_t op,
  output sqsm_pkg::queue_stat_t stat
);

  sqsm_pkg::item_t mem [sqsm_pkg::QUEUE_DEPTH];

  logic [sqsm_pkg::ADDR_W-1:0] head;
  logic [sqsm_pkg::ADDR_W-1:0] head_next;
  logic [sqsm_pkg::CNT_W-1:0]  count;
  logic [sqsm_pkg::CNT_W-1:0]  count_next;
  logic [sqsm_pkg::ADDR_W-1:0] wr_addr;
  logic [sqsm_pkg::ADDR_W:0]   wr_sum;
  logic [sqsm_pkg::ADDR_W:0]   head_inc;

  sqsm_pkg::item_t rd_q;
  sqsm_pkg::item_t byp_data;
  logic            byp;

  // tail slot, wrapped modulo the depth
  always_comb begin
    wr_sum = {1'b0, head} + (sqsm_pkg::ADDR_W + 1)'(count);
    if (wr_sum >= (sqsm_pkg::ADDR_W + 1)'(sqsm_pkg::QUEUE_DEPTH)) begin
      wr_sum = wr_sum - (sqsm_pkg::ADDR_W + 1)'(sqsm_pkg::QUEUE_DEPTH);
    end
    wr_addr = wr_sum[sqsm_pkg::ADDR_W-1:0];
  end

  always_comb begin
    head_inc   = {1'b0, head} + 1'b1;
    head_next  = head;
    count_next = count;
    if (op.pop) begin
      head_next  = (head_inc >= (sqsm_pkg::ADDR_W + 1)'(sqsm_pkg::QUEUE_DEPTH)) ?
                   '0 : head_inc[sqsm_pkg::ADDR_W-1:0];
      count_next = count - 1'b1;
    end else if (op.push) begin
      count_next = count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      byp   <= 1'b0;
    end else begin
      head  <= head_next;
      count <= count_next;
      byp   <= op.push && (wr_addr == head_next);
    end
  end

  always_ff @(posedge clk) begin
    if (op.push) begin
      mem[wr_addr] <= op.data;
    end
    rd_q     <= mem[head_next];
    byp_data <= op.data;
  end

  assign stat.count     = count;
  assign stat.head_data = byp ? byp_data : rd_q;

endmodule

// ===== rtl/sqsm_ctrl.sv =====
// slot timing and server state, decides push, pop, departure and drop
module sqsm_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic                            command,
  input  sqsm_pkg::item_t                 item,
  input  logic [sqsm_pkg::SERVICE_W-1:0]  service_time,
  input  logic [sqsm_pkg::LIMIT_W-1:0]    queue_limit,
  input  sqsm_pkg::queue_stat_t           qstat,
  output sqsm_pkg::queue_op_t             qop,
  output sqsm_pkg::result_t               res
);

  logic [sqsm_pkg::SERVICE_W-1:0] phase;
  logic [sqsm_pkg::SERVICE_W-1:0] phase_next;
  logic [1:0]                     mode;
  logic [1:0]                     mode_next;
  sqsm_pkg::item_t                server_item;
  sqsm_pkg::item_t                server_item_next;

  logic [sqsm_pkg::SERVICE_W-1:0] eff_service;
  logic [sqsm_pkg::SERVICE_W-1:0] phase_inc;
  logic [sqsm_pkg::CMP_W-1:0]     lim_eff;
  logic [sqsm_pkg::CMP_W-1:0]     count_ext;
  logic                           can_push;
  logic                           q_empty;

  always_comb begin
    eff_service = (service_time == '0) ? sqsm_pkg::SERVICE_W'(1) : service_time;
    phase_inc   = phase + 1'b1;
    // limit above the store depth saturates
    lim_eff     = (sqsm_pkg::CMP_W'(queue_limit) > sqsm_pkg::CMP_W'(sqsm_pkg::QUEUE_DEPTH)) ?
                  sqsm_pkg::CMP_W'(sqsm_pkg::QUEUE_DEPTH) : sqsm_pkg::CMP_W'(queue_limit);
    count_ext   = sqsm_pkg::CMP_W'(qstat.count);
    can_push    = count_ext < lim_eff;
    q_empty     = (qstat.count == '0);
  end

  always_comb begin
    phase_next       = phase;
    mode_next        = mode;
    server_item_next = server_item;
    qop.push         = 1'b0;
    qop.pop          = 1'b0;
    qop.data         = item;
    res.valid        = 1'b0;
    res.kind         = sqsm_pkg::KIND_DEPART;
    res.item         = item;
    if (accept) begin
      if (command == sqsm_pkg::CMD_TICK) begin
        phase_next = (phase_inc >= eff_service) ? '0 : phase_inc;
        if (phase_next == '0) begin
          case (mode)
            sqsm_pkg::MODE_SERVING: begin
              res.valid = 1'b1;
              res.kind  = sqsm_pkg::KIND_DEPART;
              res.item  = server_item;
              if (!q_empty) begin
                qop.pop          = 1'b1;
                server_item_next = qstat.head_data;
              end else begin
                server_item_next = '0;
                mode_next        = sqsm_pkg::MODE_IDLE;
              end
            end
            sqsm_pkg::MODE_SYNCING: begin
              if (!q_empty) begin
                qop.pop          = 1'b1;
                server_item_next = qstat.head_data;
                mode_next        = sqsm_pkg::MODE_SERVING;
              end else begin
                mode_next = sqsm_pkg::MODE_IDLE;
              end
            end
            default: begin
            end
          endcase
        end
      end else if (mode != sqsm_pkg::MODE_IDLE) begin
        if (can_push) begin
          qop.push = 1'b1;
        end else begin
          res.valid = 1'b1;
          res.kind  = sqsm_pkg::KIND_DROP;
        end
      end else if (phase == '0) begin
        server_item_next = item;
        mode_next        = sqsm_pkg::MODE_SERVING;
      end else if (can_push) begin
        qop.push  = 1'b1;
        mode_next = sqsm_pkg::MODE_SYNCING;
      end else begin
        res.valid = 1'b1;
        res.kind  = sqsm_pkg::KIND_DROP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= '0;
      mode        <= sqsm_pkg::MODE_IDLE;
      server_item <= '0;
    end else begin
      phase       <= phase_next;
      mode        <= mode_next;
      server_item <= server_item_next;
    end
  end

endmodule

// ===== rtl/sqsm_out_buf.sv =====
// two-entry result buffer between the controller and the output channel
module sqsm_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  sqsm_pkg::result_t   res,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                kind,
  output sqsm_pkg::item_t     item_res
);

  logic [1:0]        cnt;
  logic [1:0]        cnt_next;
  logic              e0_kind;
  logic              e1_kind;
  sqsm_pkg::item_t   e0_item;
  sqsm_pkg::item_t   e1_item;
  logic              pop;

  assign pop = (cnt != 2'd0) && !out_stall;

  always_comb begin
    cnt_next = cnt;
    case ({res.valid, pop})
      2'b10:   cnt_next = cnt + 1'b1;
      2'b01:   cnt_next = cnt - 1'b1;
      default: cnt_next = cnt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // new result lands in the front entry when it will be the only one left
  always_ff @(posedge clk) begin
    if (res.valid && (cnt_next == 2'd1)) begin
      e0_kind <= res.kind;
      e0_item <= res.item;
    end else if (pop) begin
      e0_kind <= e1_kind;
      e0_item <= e1_item;
    end
    if (res.valid && (cnt_next == 2'd2)) begin
      e1_kind <= res.kind;
      e1_item <= res.item;
    end
  end

  assign full      = (cnt == 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign kind      = e0_kind;
  assign item_res  = e0_item;

endmodule

// ===== rtl/slotted_queue_server_mux.sv =====
// top level of the slotted single-server fifo multiplexer
//
// one fifo feeds one server whose output runs in slots of service_time ticks.
// each input beat is an arrival (command 0, tag on item) or a tick (command 1).
// on a tick that lands on a slot start a serving server emits its item as a
// departure result and takes the queue head if any; arrivals go straight
// into an idle server at a slot start, otherwise into the queue, and an
// arrival that finds the queue at queue_limit comes back as a drop result.
// rate: one input beat per cycle while in_stall is low; the whole step is a
// single registered pass through the controller, with the queue head held
// prefetched in a register so a pop needs no read wait. results are
// registered in a two-entry buffer before they show on the output; in_stall is
// high only while both entries hold results the sink has not yet taken. config
// writes are taken at any time but are only meaningful while the block is idle.
module slotted_queue_server_mux (
  input  logic                          clk,
  input  logic                          rst,
  // config write port
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [sqsm_pkg::CFG_W-1:0]    cfg_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          command,
  input  logic [sqsm_pkg::ITEM_WIDTH-1:0] item,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          kind,
  output logic [sqsm_pkg::ITEM_WIDTH-1:0] item_res
);

  logic [sqsm_pkg::SERVICE_W-1:0] service_time;
  logic [sqsm_pkg::LIMIT_W-1:0]   queue_limit;
  logic                           accept;
  logic                           full;

  sqsm_pkg::queue_op_t   qop;
  sqsm_pkg::queue_stat_t qstat;
  sqsm_pkg::result_t     res;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      service_time <= sqsm_pkg::SERVICE_W'(2);
      queue_limit  <= sqsm_pkg::LIMIT_W'(10);
    end else if (cfg_we) begin
      case (cfg_index)
        sqsm_pkg::REG_SERVICE_TIME: service_time <= cfg_data[sqsm_pkg::SERVICE_W-1:0];
        sqsm_pkg::REG_QUEUE_LIMIT:  queue_limit  <= cfg_data[sqsm_pkg::LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input beat taken whenever the result buffer has a free entry
  assign in_stall = full;
  assign accept   = in_valid && !full;

  sqsm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .command      (command),
    .item         (item),
    .service_time (service_time),
    .queue_limit  (queue_limit),
    .qstat        (qstat),
    .qop          (qop),
    .res          (res)
  );

  sqsm_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .op   (qop),
    .stat (qstat)
  );

  sqsm_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .item_res  (item_res)
  );

endmodule

// ===== verif/tb_slotted_queue_server_mux.sv =====
// self-checking testbench for the slotted queue server mux: directed table, then random phases
module tb_slotted_queue_server_mux;

  // one result beat as the block should produce it
  typedef struct packed {
    logic            kind;
    sqsm_pkg::item_t tag;
  } owed_t;

  // directed table: a beat on the input channel or a register write between phases
  typedef enum logic [1:0] {ROW_BEAT, ROW_SET_SERVICE, ROW_SET_LIMIT} row_op_e;
  // how a beat row is checked: by the predictor, no result typed in, or a result typed in
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_GIVEN} row_chk_e;

  typedef struct packed {
    row_op_e         op;
    logic            cmd;
    logic [15:0]     val;
    row_chk_e        chk;
    logic            kind;
    sqsm_pkg::item_t res;
  } plan_row_t;

  localparam int PLAN_ROWS   = 35;
  localparam int STALL_LIMIT = 5000;
  localparam int RAND_PHASES = 11;
  localparam int PHASE_BEATS = 120;

  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // after reset: service time 2, limit 10, idle at a slot start
    '{ROW_BEAT, sqsm_pkg::CMD_ARRIVAL, 16'hFFFF, CHK_NONE, sqsm_pkg::KIND_DEPART, 16'h0000},
    '{ROW_BEAT, sqsm_pkg::CMD_ARRIVAL, 16'h0000, CHK_NONE, sqsm_pkg::KIND_DEPART, 16'h0000},
    '{ROW_BEAT, sqsm_pkg::CMD_TICK, 16'h0000, CHK_NONE, sqsm_pkg::KIND_DEPART, 16'h0000},
    '{ROW_BEAT, sqsm_pkg::CMD_TICK, 16'h0000, CHK_GIVEN, sqsm_pkg::KIND_DEPART, 16'hFFFF},
    '{ROW_BEAT, sqsm_pkg::CMD_TICK, 16'h0000, CHK_MODEL, sqsm_pkg::KIND_DEPART, 16'h0000},
    '{ROW_BEAT, sqsm_pkg::CMD_ARRIVAL, 16'h7FFE, CHK_MODEL, sqsm_pkg::KIND_DEPART, 16'h0000},
    '{ROW_BEAT, sqsm_pkg::CMD_TICK, 16'h0000, CHK_MODEL, sqsm_pkg::KIND_DEPART, 16'h0000},
    '{ROW_BEAT, sqsm_pkg::CMD_TICK, 16'h0000, CHK_MODEL, sqsm_pkg::KIND_DEPART, 16'h0000},
    '{ROW_BEAT, sqsm_pkg::CMD_TICK, 16'h0000, CHK_MODEL, sqsm_pkg::KIND_DEPART, 16'h0000},
    // idle server off a slot start: arrival is queued, server syncs
    '{ROW_BEAT, sqsm_pkg::CMD_TICK, 16'h0000, CHK_MODEL, sqsm_pkg::KIND_DEPART, 16'h0000},
    '{ROW_BEAT, sqsm_pkg::CMD_ARRIVAL, 16'h8001, CHK_MODEL, sqsm_pkg::KIND_DEPART, 16'h0000},
    '{ROW_BEAT, sqsm_pkg::CMD_TICK, 16'h0000, CHK_MODEL, sqsm_pkg::KIND_DEPART, 16'h0000},
    // service time zero acts as one; limit zero drops every queued arrival
    '{ROW_SET_SERVICE, sqsm_pkg::CMD_TICK, 16'd0, CHK_MODEL, sqsm_pkg::KIND_DEPART, 16'h0000},
    '{ROW_SET_LIMIT, sqsm_pkg::CMD_TICK, 16'd0, CHK_MODEL, sqsm_pkg::KIND_DEPART, 16'h0000},
    '{ROW_BEAT, sqsm_pkg::CMD_ARRIVAL, 16'h5555, CHK_GIVEN, sqsm_pkg::KIND_DROP, 16'h5555},
    '{ROW_BEAT, sqsm_pkg::CMD_TICK, 16'h0000, CHK_MODEL, sqsm_pkg::KIND_DEPART, 16'h0000},
    '{ROW_BEAT, sqsm_pkg::CMD_ARRIVAL, 16'hAAAA, CHK_MODEL, sqsm_pkg::KIND_DEPART, 16'h0000},
    '{ROW_BEAT, sqsm_pkg::CMD_TICK, 16'h0000, CHK_MODEL, sqsm_pkg::KIND_DEPART, 16'h0000},
    // drop at an idle server leaves it idle
    '{ROW_SET_SERVICE, sqsm_pkg::CMD_TICK, 16'd255, CHK_MODEL, sqsm_pkg::KIND_DEPART, 16'h0000},
    '{ROW_BEAT, sqsm_pkg::CMD_TICK, 16'h0000, CHK_MODEL, sqsm_pkg::KIND_DEPART, 16'h0000},
    '{ROW_BEAT, sqsm_pkg::CMD_ARRIVAL, 16'h00FF, CHK_GIVEN, sqsm_pkg::KIND_DROP, 16'h00FF},
    // full queue at limit one
    '{ROW_SET_LIMIT, sqsm_pkg::CMD_TICK, 16'd1, CHK_MODEL, sqsm_pkg::KIND_DEPART, 16'h0000},
    '{ROW_BEAT, sqsm_pkg::CMD_TICK, 16'h0000, CHK_MODEL, sqsm_pkg::KIND_DEPART, 16'h0000},
    '{ROW_BEAT, sqsm_pkg::CMD_ARRIVAL, 16'h0F0F, CHK_MODEL, sqsm_pkg::KIND_DEPART, 16'h0000},
    '{ROW_BEAT, sqsm_pkg::CMD_ARRIVAL, 16'hF0F0, CHK_GIVEN, sqsm_pkg::KIND_DROP, 16'hF0F0},
    // phase left beyond a lowered service time wraps on the next tick
    '{ROW_SET_SERVICE, sqsm_pkg::CMD_TICK, 16'd1, CHK_MODEL, sqsm_pkg::KIND_DEPART, 16'h0000},
    '{ROW_BEAT, sqsm_pkg::CMD_TICK, 16'h0000, CHK_MODEL, sqsm_pkg::KIND_DEPART, 16'h0000},
    // limit above the depth saturates, then lowered below the fill
    '{ROW_SET_LIMIT, sqsm_pkg::CMD_TICK, 16'd127, CHK_MODEL, sqsm_pkg::KIND_DEPART, 16'h0000},
    '{ROW_BEAT, sqsm_pkg::CMD_ARRIVAL, 16'h1111, CHK_MODEL, sqsm_pkg::KIND_DEPART, 16'h0000},
    '{ROW_BEAT, sqsm_pkg::CMD_ARRIVAL, 16'h2222, CHK_MODEL, sqsm_pkg::KIND_DEPART, 16'h0000},
    '{ROW_SET_LIMIT, sqsm_pkg::CMD_TICK, 16'd1, CHK_MODEL, sqsm_pkg::KIND_DEPART, 16'h0000},
    '{ROW_BEAT, sqsm_pkg::CMD_ARRIVAL, 16'h4444, CHK_GIVEN, sqsm_pkg::KIND_DROP, 16'h4444},
    '{ROW_BEAT, sqsm_pkg::CMD_TICK, 16'h0000, CHK_MODEL, sqsm_pkg::KIND_DEPART, 16'h0000},
    '{ROW_BEAT, sqsm_pkg::CMD_TICK, 16'h0000, CHK_MODEL, sqsm_pkg::KIND_DEPART, 16'h0000},
    '{ROW_BEAT, sqsm_pkg::CMD_TICK, 16'h0000, CHK_MODEL, sqsm_pkg::KIND_DEPART, 16'h0000}
  };

  logic                            clk;
  logic                            rst       = 1'b1;
  logic                            cfg_we    = 1'b0;
  logic                            cfg_index = sqsm_pkg::REG_SERVICE_TIME;
  logic [sqsm_pkg::CFG_W-1:0]      cfg_data  = '0;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  logic                            command   = sqsm_pkg::CMD_TICK;
  logic [sqsm_pkg::ITEM_WIDTH-1:0] item      = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic                            kind;
  logic [sqsm_pkg::ITEM_WIDTH-1:0] item_res;

  slotted_queue_server_mux u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .item      (item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .item_res  (item_res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // predictor copy of the block: registers, fifo and server
  logic [7:0]      svc_ticks = 8'd2;
  logic [6:0]      fill_cap  = 7'd10;
  sqsm_pkg::item_t fifo_mem [sqsm_pkg::QUEUE_DEPTH];
  int              fifo_head = 0;
  int              fifo_fill = 0;
  sqsm_pkg::item_t srv_tag   = '0;
  logic [1:0]      srv_mode  = sqsm_pkg::MODE_IDLE;
  logic [7:0]      slot_phase = '0;

  // results still owed by the block, oldest first
  owed_t owed [$];
  int    fail_count = 0;
  int    burst_left = 0;
  int    quiet_cycles = 0;

  function automatic sqsm_pkg::item_t fifo_pop();
    sqsm_pkg::item_t head_tag;
    head_tag  = fifo_mem[fifo_head];
    fifo_head = (fifo_head + 1) % sqsm_pkg::QUEUE_DEPTH;
    fifo_fill--;
    return head_tag;
  endfunction

  // advance the mux by one beat; returns 1 when the beat yields a result
  function automatic bit mux_step(input logic cmd, input sqsm_pkg::item_t tag,
                                  output owed_t ev);
    int span;
    int cap;
    span = (svc_ticks == 8'd0) ? 1 : int'(svc_ticks);
    cap  = (int'(fill_cap) > sqsm_pkg::QUEUE_DEPTH) ? sqsm_pkg::QUEUE_DEPTH : int'(fill_cap);
    ev   = '0;
    if (cmd == sqsm_pkg::CMD_TICK) begin
      slot_phase = slot_phase + 8'd1;
      if (int'(slot_phase) >= span) slot_phase = '0;
      if (slot_phase != 8'd0) return 1'b0;
      // slot start: server acts before any arrival of this tick
      if (srv_mode == sqsm_pkg::MODE_SERVING) begin
        ev.kind = sqsm_pkg::KIND_DEPART;
        ev.tag  = srv_tag;
        if (fifo_fill != 0) begin
          srv_tag = fifo_pop();
        end else begin
          srv_tag  = '0;
          srv_mode = sqsm_pkg::MODE_IDLE;
        end
        return 1'b1;
      end
      if (srv_mode == sqsm_pkg::MODE_SYNCING) begin
        if (fifo_fill != 0) begin
          srv_tag  = fifo_pop();
          srv_mode = sqsm_pkg::MODE_SERVING;
        end else begin
          srv_mode = sqsm_pkg::MODE_IDLE;
        end
      end
      return 1'b0;
    end
    // arrival straight into an idle server at a slot start
    if (srv_mode == sqsm_pkg::MODE_IDLE && slot_phase == 8'd0) begin
      srv_tag  = tag;
      srv_mode = sqsm_pkg::MODE_SERVING;
      return 1'b0;
    end
    if (fifo_fill < cap && fifo_fill < sqsm_pkg::QUEUE_DEPTH) begin
      fifo_mem[(fifo_head + fifo_fill) % sqsm_pkg::QUEUE_DEPTH] = tag;
      fifo_fill++;
      if (srv_mode == sqsm_pkg::MODE_IDLE) srv_mode = sqsm_pkg::MODE_SYNCING;
      return 1'b0;
    end
    // queue at its limit: the arrival comes back as a drop, server mode unchanged
    ev.kind = sqsm_pkg::KIND_DROP;
    ev.tag  = tag;
    return 1'b1;
  endfunction

  // drive one input beat inside the burst/gap pattern and book what it owes
  task automatic send_beat(input logic cmd, input sqsm_pkg::item_t tag, input row_chk_e chk,
                           input logic given_kind, input sqsm_pkg::item_t given_tag);
    int    gap;
    owed_t ev;
    bit    yields;
    if (burst_left == 0) begin
      // a quarter of the bursts follow on with no gap at all
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    command  <= cmd;
    item     <= tag;
    // beat taken at the first edge with stall low
    do @(posedge clk); while (in_stall !== 1'b0);
    yields = mux_step(cmd, tag, ev);
    case (chk)
      CHK_MODEL: if (yields) owed.push_back(ev);
      CHK_GIVEN: owed.push_back('{kind: given_kind, tag: given_tag});
      default: ;
    endcase
  endtask

  // let the block drain before touching a register
  task automatic settle();
    in_valid <= 1'b0;
    while (owed.size() != 0) @(posedge clk);
    // the last beat may have caused no result yet still be in flight
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == sqsm_pkg::REG_SERVICE_TIME) svc_ticks = value;
    else fill_cap = value[6:0];
    @(posedge clk);
  endtask

  // result checker: every accepted result beat against the oldest owed one
  always @(posedge clk) begin : check_results
    owed_t want;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (owed.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, got kind %0d item %h",
                 $time, kind, item_res);
      end else begin
        want = owed.pop_front();
        if (kind !== want.kind || item_res !== want.tag) begin
          fail_count++;
          $display("%0t: result mismatch, expected kind %0d item %h, got kind %0d item %h",
                   $time, want.kind, want.tag, kind, item_res);
        end
      end
    end
  end

  // sink stall pattern: modes of random length, from never stalling to mostly stalled
  int stall_mode = 0;
  int mode_left  = 0;
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(20, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (mode_left[3:0] < 4'd12);
    endcase
  end

  // watchdog: too long with no beat taken on either side
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (!rst && out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    plan_row_t row;
    logic [7:0] svc;
    logic [7:0] cap;
    int tick_pct;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int r = 0; r < PLAN_ROWS; r++) begin
      row = PLAN[r];
      case (row.op)
        ROW_BEAT: send_beat(row.cmd, sqsm_pkg::item_t'(row.val), row.chk, row.kind, row.res);
        ROW_SET_SERVICE: begin
          settle();
          write_reg(sqsm_pkg::REG_SERVICE_TIME, row.val[7:0]);
        end
        default: begin
          settle();
          write_reg(sqsm_pkg::REG_QUEUE_LIMIT, row.val[7:0]);
        end
      endcase
    end

    // random phases, each under its own register setting
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        // every tick a slot start, full depth
        0: begin
          svc = 8'd1;   cap = 8'd64;  tick_pct = 50;
        end
        // longest slot, saturated limit, arrivals overrun the fifo
        1: begin
          svc = 8'd255; cap = 8'd127; tick_pct = 10;
        end
        // service time zero drains the backlog
        2: begin
          svc = 8'd0;   cap = 8'd3;   tick_pct = 60;
        end
        // limit zero: only direct intake at slot starts survives
        3: begin
          svc = 8'd2;   cap = 8'd0;   tick_pct = 50;
        end
        default: begin
          svc = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(1, 6));
          cap = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 127))
                                            : 8'($urandom_range(1, 12));
          tick_pct = $urandom_range(30, 70);
        end
      endcase
      settle();
      write_reg(sqsm_pkg::REG_SERVICE_TIME, svc);
      write_reg(sqsm_pkg::REG_QUEUE_LIMIT, cap);
      repeat (PHASE_BEATS) begin
        send_beat(($urandom_range(0, 99) < tick_pct) ? sqsm_pkg::CMD_TICK
                                                     : sqsm_pkg::CMD_ARRIVAL,
                  sqsm_pkg::item_t'($urandom()), CHK_MODEL, sqsm_pkg::KIND_DEPART, '0);
      end
    end

    // drain, then allow a few cycles for any stray result
    in_valid <= 1'b0;
    while (owed.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
